// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ptts_pkg.sv
// types and constants of the periodic task tick scheduler
`default_nettype none

package ptts_pkg;

   localparam int DEF_TIMER_TASKS = 16;
   localparam int DEF_EVENT_TASKS = 4;

   localparam int FUNC_W = 2;
   localparam int TASK_W = 4;
   localparam int TICK_W = 32;
   localparam int KIND_W = 2;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [FUNC_W-1:0] {
      OP_TICK   = 2'd0,
      OP_ARM    = 2'd1,
      OP_CANCEL = 2'd2,
      OP_RAISE  = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TIMER = 2'd0,
      KIND_EVENT = 2'd1,
      KIND_ACK   = 2'd2
   } kind_type;

   typedef struct packed {
      op_type              op;
      logic [TASK_W-1:0]   idx;
      logic                idx_ok;
      logic [TICK_W-1:0]   period;
   } cmd_type;

   typedef struct packed {
      kind_type            kind;
      logic [TASK_W-1:0]   task_num;
      logic                addressed_flag;
      logic [TICK_W-1:0]   tick_now;
      logic                last;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/ptts_if.sv
// request and response channel interfaces
`default_nettype none

interface ptts_req_if;
   logic                          valid;
   logic                          ready;
   logic [ptts_pkg::FUNC_W-1:0]   func;
   logic [ptts_pkg::TASK_W-1:0]   task_index;
   logic [ptts_pkg::TICK_W-1:0]   period;

   modport source (output valid, func, task_index, period, input ready);
   modport sink (input valid, func, task_index, period, output ready);
endinterface

interface ptts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ptts_pkg::KIND_W-1:0]   kind;
   logic [ptts_pkg::TASK_W-1:0]   task_num;
   logic                          addressed_flag;
   logic [ptts_pkg::TICK_W-1:0]   tick_now;
   logic                          last;

   modport source (output valid, kind, task_num, addressed_flag, tick_now, last,
                   input ready);
   modport sink (input valid, kind, task_num, addressed_flag, tick_now, last,
                 output ready);
endinterface

`default_nettype wire

// File: sv/ptts_front.sv
// request decode and command queue
`default_nettype none

module ptts_front #(
   parameter int TIMER_TASKS = ptts_pkg::DEF_TIMER_TASKS,
   parameter int EVENT_TASKS = ptts_pkg::DEF_EVENT_TASKS
) (
   input  logic               clock,
   input  logic               reset,
   ptts_req_if.sink           req_ch,
   output logic               cmd_valid,
   output ptts_pkg::cmd_type  cmd_data,
   input  logic               cmd_ready
);
   import ptts_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [TASK_W:0] T_LIM = (TASK_W + 1)'(TIMER_TASKS);
   localparam logic [TASK_W:0] E_LIM = (TASK_W + 1)'(EVENT_TASKS);

   cmd_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    cnt_ff, cnt_in;
   cmd_type              dec;
   logic                 push, pop;

   // classify the incoming item
   always_comb begin
      dec.op     = op_type'(req_ch.func);
      dec.idx    = req_ch.task_index;
      dec.period = req_ch.period;
      unique case (dec.op) inside
         OP_TICK: begin
            dec.idx_ok = 1'b0;
         end
         OP_ARM, OP_CANCEL: begin
            dec.idx_ok = ({1'b0, req_ch.task_index} < T_LIM);
         end
         OP_RAISE: begin
            dec.idx_ok = ({1'b0, req_ch.task_index} < E_LIM);
         end
         default: begin
            dec.idx_ok = 1'b0;
         end
      endcase
   end

   assign req_ch.ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid    = (cnt_ff != '0);
   assign cmd_data     = queue_ff[rd_ptr_ff];
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

// File: sv/ptts_back.sv
// task table, tick scan and response register
`default_nettype none

module ptts_back #(
   parameter int TIMER_TASKS = ptts_pkg::DEF_TIMER_TASKS,
   parameter int EVENT_TASKS = ptts_pkg::DEF_EVENT_TASKS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  ptts_pkg::cmd_type  cmd_data,
   output logic               cmd_ready,
   ptts_rsp_if.source         rsp_ch
);
   import ptts_pkg::*;

   localparam int TIW    = (TIMER_TASKS > 1) ? $clog2(TIMER_TASKS) : 1;
   localparam int EIW    = (EVENT_TASKS > 1) ? $clog2(EVENT_TASKS) : 1;
   localparam int SCAN_N = TIMER_TASKS + EVENT_TASKS;
   localparam int SCAN_W = $clog2(SCAN_N);
   localparam logic [SCAN_W-1:0] LAST_SCAN = SCAN_W'(SCAN_N - 1);
   localparam logic [SCAN_W-1:0] T_SCAN    = SCAN_W'(TIMER_TASKS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [SCAN_W-1:0]       scan_ff, scan_in;
   logic [TICK_W-1:0]       count_ff, count_in;
   logic [TIMER_TASKS-1:0]  en_ff, en_in;
   logic [EVENT_TASKS-1:0]  ev_ff, ev_in;
   logic [TICK_W-1:0]       period_ff [TIMER_TASKS];
   logic [TICK_W-1:0]       period_in [TIMER_TASKS];
   logic [TICK_W-1:0]       dl_ff [TIMER_TASKS];
   logic [TICK_W-1:0]       dl_in [TIMER_TASKS];
   logic                    held_valid_ff, held_valid_in;
   kind_type                held_kind_ff, held_kind_in;
   logic [TASK_W-1:0]       held_num_ff, held_num_in;
   logic                    out_valid_ff;
   rsp_type                 out_ff;

   logic                    can_push, push;
   rsp_type                 push_data;
   logic                    timer_sel, hit;
   logic [TIW-1:0]          t_idx, c_tidx;
   logic [EIW-1:0]          e_idx, c_eidx;
   logic [SCAN_W-1:0]       ev_off;

   assign can_push  = !out_valid_ff || rsp_ch.ready;
   assign timer_sel = (scan_ff < T_SCAN);
   assign t_idx     = scan_ff[TIW-1:0];
   assign ev_off    = scan_ff - T_SCAN;
   assign e_idx     = ev_off[EIW-1:0];
   assign c_tidx    = cmd_data.idx[TIW-1:0];
   assign c_eidx    = cmd_data.idx[EIW-1:0];
   assign hit       = timer_sel ? (en_ff[t_idx] && (count_ff >= dl_ff[t_idx]))
                                : ev_ff[e_idx];

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      count_in      = count_ff;
      en_in         = en_ff;
      ev_in         = ev_ff;
      period_in     = period_ff;
      dl_in         = dl_ff;
      held_valid_in = held_valid_ff;
      held_kind_in  = held_kind_ff;
      held_num_in   = held_num_ff;
      cmd_ready     = 1'b0;
      push          = 1'b0;
      push_data     = '0;
      push_data.tick_now = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd_data.op == OP_TICK) begin
                  cmd_ready = 1'b1;
                  count_in  = count_ff + 1'b1;
                  scan_in   = '0;
                  state_in  = ST_SCAN;
               end else if (can_push) begin
                  cmd_ready          = 1'b1;
                  push               = 1'b1;
                  push_data.kind     = KIND_ACK;
                  push_data.task_num = cmd_data.idx;
                  push_data.last     = 1'b1;
                  case (cmd_data.op)
                     OP_ARM: begin
                        if (cmd_data.idx_ok) begin
                           en_in[c_tidx]     = 1'b1;
                           period_in[c_tidx] = cmd_data.period;
                           dl_in[c_tidx]     = count_ff + cmd_data.period;
                        end
                        push_data.addressed_flag = cmd_data.idx_ok;
                     end
                     OP_CANCEL: begin
                        if (cmd_data.idx_ok) begin
                           en_in[c_tidx] = 1'b0;
                        end
                        push_data.addressed_flag = 1'b0;
                     end
                     default: begin
                        if (cmd_data.idx_ok) begin
                           ev_in[c_eidx] = 1'b1;
                        end
                        push_data.addressed_flag = cmd_data.idx_ok;
                     end
                  endcase
               end
            end
         end
         ST_SCAN: begin
            // a new hit flushes the held result, which is then known not to be last
            if (!(hit && held_valid_ff && !can_push)) begin
               if (hit) begin
                  if (timer_sel) begin
                     dl_in[t_idx] = count_ff + period_ff[t_idx];
                     held_kind_in = KIND_TIMER;
                     held_num_in  = TASK_W'(t_idx);
                  end else begin
                     ev_in[e_idx] = 1'b0;
                     held_kind_in = KIND_EVENT;
                     held_num_in  = TASK_W'(e_idx);
                  end
                  if (held_valid_ff) begin
                     push               = 1'b1;
                     push_data.kind     = held_kind_ff;
                     push_data.task_num = held_num_ff;
                  end
                  held_valid_in = 1'b1;
               end
               if (scan_ff == LAST_SCAN) begin
                  state_in = ST_DONE;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!held_valid_ff) begin
               state_in = ST_IDLE;
            end else if (can_push) begin
               push               = 1'b1;
               push_data.kind     = held_kind_ff;
               push_data.task_num = held_num_ff;
               push_data.last     = 1'b1;
               held_valid_in      = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ff       <= '0;
         count_ff      <= '0;
         en_ff         <= '0;
         ev_ff         <= '0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         count_ff      <= count_in;
         en_ff         <= en_in;
         ev_ff         <= ev_in;
         held_valid_ff <= held_valid_in;
         if (push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      period_ff    <= period_in;
      dl_ff        <= dl_in;
      held_kind_ff <= held_kind_in;
      held_num_ff  <= held_num_in;
      if (push) begin
         out_ff <= push_data;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.kind           = out_ff.kind;
   assign rsp_ch.task_num       = out_ff.task_num;
   assign rsp_ch.addressed_flag = out_ff.addressed_flag;
   assign rsp_ch.tick_now       = out_ff.tick_now;
   assign rsp_ch.last           = out_ff.last;

endmodule

`default_nettype wire

// File: sv/periodic_task_tick_scheduler.sv
// arm, cancel and raise: one acknowledge, after the front queue and the output register
// a tick holds the back end while it scans TIMER_TASKS + EVENT_TASKS entries, one table entry or
// event flag per cycle while no new hit waits on a full output register
// the front queue holds two items, so up to two more requests are taken while a tick is scanned
// results leave through one output register, one transfer per cycle at most; stalls hold it
// synchronous reset clears the counter, all enables and pending flags, the queue and the output
`default_nettype none

module periodic_task_tick_scheduler #(
   parameter int TIMER_TASKS = ptts_pkg::DEF_TIMER_TASKS,
   parameter int EVENT_TASKS = ptts_pkg::DEF_EVENT_TASKS
) (
   input  logic        clock,
   input  logic        reset,
   ptts_req_if.sink    req_ch,
   ptts_rsp_if.source  rsp_ch
);
   import ptts_pkg::*;

   logic     cmd_valid;
   logic     cmd_ready;
   cmd_type  cmd_data;

   ptts_front #(
      .TIMER_TASKS (TIMER_TASKS),
      .EVENT_TASKS (EVENT_TASKS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_ready (cmd_ready)
   );

   ptts_back #(
      .TIMER_TASKS (TIMER_TASKS),
      .EVENT_TASKS (EVENT_TASKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_ready (cmd_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// File: sv/ptts_checker.sv
// port-level checks of the scheduler and their bind
`default_nettype none
`include "assert_macros.svh"

module ptts_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [ptts_pkg::KIND_W-1:0]   rsp_kind,
   input wire logic                          rsp_flag,
   input wire logic                          rsp_last
);
   import ptts_pkg::*;

   // a stalled response stays offered
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // due results never carry the addressed flag
   `ASSERT_CLK_RST(a_due_flag, clock, reset, rsp_valid && rsp_kind != KIND_ACK |-> !rsp_flag, "flag set on a due result")

   // an arm, cancel or raise command gives exactly one result, so its acknowledge closes it
   `ASSERT_CLK_RST(a_ack_last, clock, reset, rsp_valid && rsp_kind == KIND_ACK |-> rsp_last, "acknowledge not marked last")

   // no response is offered right after reset
   `ASSERT_CLK(a_reset_idle, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind periodic_task_tick_scheduler ptts_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_kind  (rsp_ch.kind),
   .rsp_flag  (rsp_ch.addressed_flag),
   .rsp_last  (rsp_ch.last)
);

`default_nettype wire
